>>> rtl/fcbg_pkg.sv
package fcbg_pkg;

  localparam int unsigned NumBands    = 8;
  localparam int unsigned TempWidth   = 19;
  localparam int unsigned BandWidth   = 4;
  localparam int unsigned RpmWidth    = 14;
  localparam int unsigned DegWidth    = 7;
  localparam int unsigned HystWidth   = 4;
  localparam int unsigned HystMdegW   = 14;
  localparam int unsigned ThrMdegW    = 17;
  localparam int unsigned TableWidth  = 56;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDatWidth = 56;
  localparam int unsigned MdegPerDeg  = 1000;

  localparam logic signed [TempWidth-1:0] TempMinMdeg = -19'sd40000;
  localparam logic signed [TempWidth-1:0] TempMaxMdeg = 19'sd150000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_BAND_COUNT = 3'd0,
    CFG_HYSTERESIS = 3'd1,
    CFG_THRESHOLDS = 3'd2,
    CFG_RPM_LOW    = 3'd3,
    CFG_RPM_MID    = 3'd4,
    CFG_RPM_TOP    = 3'd5
  } fcbg_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_FINISH
  } fcbg_state_e;

  typedef struct packed {
    logic [BandWidth-1:0]  band_count;
    logic [HystWidth-1:0]  hysteresis_deg;
    logic [TableWidth-1:0] threshold_table;
    logic [TableWidth-1:0] rpm_table_low;
    logic [TableWidth-1:0] rpm_table_mid;
    logic [RpmWidth-1:0]   rpm_table_top;
  } fcbg_cfg_t;

  // threshold entry i in whole degrees
  function automatic logic [DegWidth-1:0] thr_deg(input logic [TableWidth-1:0] tbl,
                                                  input logic [2:0] idx);
    thr_deg = tbl[idx*DegWidth +: DegWidth];
  endfunction

  // rpm entry for a band, entry 8 and above from the top register
  function automatic logic [RpmWidth-1:0] rpm_entry(input fcbg_cfg_t cfg,
                                                    input logic [BandWidth-1:0] band);
    logic [RpmWidth-1:0] rpm;
    rpm = cfg.rpm_table_top;
    if (band < 4'd4) begin
      rpm = cfg.rpm_table_low[band[1:0]*RpmWidth +: RpmWidth];
    end else if (band < 4'd8) begin
      rpm = cfg.rpm_table_mid[band[1:0]*RpmWidth +: RpmWidth];
    end
    rpm_entry = rpm;
  endfunction

endpackage

>>> rtl/fcbg_sample_if.sv
interface fcbg_sample_if
  import fcbg_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic signed [TempWidth-1:0] temperature_mdeg;
  logic                        temperature_valid;

  modport source (output valid, output temperature_mdeg, output temperature_valid,
                  input ready);
  modport sink (input valid, input temperature_mdeg, input temperature_valid,
                output ready);
endinterface

>>> rtl/fcbg_result_if.sv
interface fcbg_result_if
  import fcbg_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [RpmWidth-1:0]  floor_rpm;
  logic [BandWidth-1:0] band_index;

  modport source (output valid, output floor_rpm, output band_index, input ready);
  modport sink (input valid, input floor_rpm, input band_index, output ready);
endinterface

>>> rtl/fcbg_cfg_if.sv
interface fcbg_cfg_if
  import fcbg_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic [CfgDatWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/fcbg_cmp_unit.sv
module fcbg_cmp_unit
  import fcbg_pkg::*;
(
  input  logic signed [TempWidth-1:0] temp_i,
  input  logic [DegWidth-1:0]         deg_i,
  input  logic [HystMdegW-1:0]        hyst_mdeg_i,
  input  logic                        use_hyst_i,
  output logic                        ge_o
);

  logic [ThrMdegW-1:0]       thr_mdeg;
  logic [HystMdegW-1:0]      hyst_sel;
  logic signed [TempWidth:0] key;
  logic signed [TempWidth:0] temp_ext;

  // threshold scaled to millidegrees, optionally lowered by the hysteresis
  assign thr_mdeg = ThrMdegW'(deg_i) * ThrMdegW'(MdegPerDeg);
  assign hyst_sel = use_hyst_i ? hyst_mdeg_i : '0;
  assign key      = $signed({3'b000, thr_mdeg}) - $signed({6'b000000, hyst_sel});
  assign temp_ext = {temp_i[TempWidth-1], temp_i};
  assign ge_o     = temp_ext >= key;

endmodule

>>> rtl/fcbg_seq.sv
module fcbg_seq
  import fcbg_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fcbg_cfg_t      cfg_i,
  fcbg_sample_if.sink    sample_i,
  fcbg_result_if.source  result_o
);

  fcbg_state_e state_q, state_d;

  logic signed [TempWidth-1:0] temp_q;
  logic [BandWidth-1:0]        bands_q, held_q, next_q, next_d;
  logic [HystMdegW-1:0]        hyst_q;
  logic                        started_q;
  logic [BandWidth-1:0]        band_q;
  logic [RpmWidth-1:0]         last_rpm_q;
  logic                        res_valid_q;
  logic [RpmWidth-1:0]         res_rpm_q;
  logic [BandWidth-1:0]        res_band_q;

  logic [BandWidth-1:0] bands_in;
  logic [BandWidth-1:0] held_in;
  logic                 in_ok;
  logic                 accept;
  logic [BandWidth-1:0] dn_idx;
  logic [2:0]           cmp_idx;
  logic                 use_hyst;
  logic                 ge;
  logic [RpmWidth-1:0]  rpm;
  logic                 emit;
  logic                 fire;

  // sample qualification at capture
  assign bands_in = (cfg_i.band_count > BandWidth'(NumBands)) ? BandWidth'(NumBands)
                                                               : cfg_i.band_count;
  assign held_in  = (band_q > bands_in) ? bands_in : band_q;
  assign in_ok    = sample_i.temperature_valid &&
                    (sample_i.temperature_mdeg >= TempMinMdeg) &&
                    (sample_i.temperature_mdeg <= TempMaxMdeg);
  assign accept   = sample_i.valid && sample_i.ready;

  // shared comparator: upward walk uses the threshold itself, downward the one below
  assign dn_idx   = next_q - 4'd1;
  assign cmp_idx  = (state_q == ST_DOWN) ? dn_idx[2:0] : next_q[2:0];
  assign use_hyst = (state_q == ST_DOWN);

  fcbg_cmp_unit u_cmp (
    .temp_i      (temp_q),
    .deg_i       (thr_deg(cfg_i.threshold_table, cmp_idx)),
    .hyst_mdeg_i (hyst_q),
    .use_hyst_i  (use_hyst),
    .ge_o        (ge)
  );

  assign rpm  = rpm_entry(cfg_i, next_q);
  assign emit = !started_q || (rpm != last_rpm_q);
  assign fire = (state_q == ST_FINISH) && (!res_valid_q || result_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          state_d = in_ok ? ST_UP : ST_FINISH;
        end
      end
      ST_UP: begin
        if (!(next_q < bands_q && ge)) begin
          state_d = (started_q && next_q < held_q) ? ST_DOWN : ST_FINISH;
        end
      end
      ST_DOWN: begin
        if (!(next_q != '0 && !ge)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and band walk
  always_comb begin
    sample_i.ready = (state_q == ST_IDLE);
    next_d         = next_q;
    case (state_q)
      ST_IDLE: begin
        next_d = in_ok ? '0 : bands_in;
      end
      ST_UP: begin
        if (next_q < bands_q && ge) begin
          next_d = next_q + 4'd1;
        end else if (started_q && next_q < held_q) begin
          next_d = held_q;
        end
      end
      ST_DOWN: begin
        if (next_q != '0 && !ge) begin
          next_d = dn_idx;
        end
      end
      default: next_d = next_q;
    endcase
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.floor_rpm  = res_rpm_q;
  assign result_o.band_index = res_band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      band_q      <= '0;
      last_rpm_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        started_q <= 1'b1;
        band_q    <= next_q;
        if (emit) begin
          last_rpm_q <= rpm;
        end
      end
      if (fire && emit) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    next_q <= next_d;
    if (accept) begin
      temp_q  <= sample_i.temperature_mdeg;
      bands_q <= bands_in;
      held_q  <= held_in;
      hyst_q  <= HystMdegW'(cfg_i.hysteresis_deg) * HystMdegW'(MdegPerDeg);
    end
    if (fire && emit) begin
      res_rpm_q  <= rpm;
      res_band_q <= next_q;
    end
  end

endmodule

>>> rtl/fan_curve_band_governor.sv
// fan floor governor: one temperature request in, at most one rpm request out.
// a valid in-range sample climbs the threshold table one entry per cycle, then,
// once the block has run before and the climb ends below the stored band, walks
// down one band per cycle while the sample is below the lower threshold minus
// the hysteresis; an invalid or out-of-range sample picks the top band. the
// band's floor rpm is sent on the first sample and afterwards only when it
// changes. the single threshold comparator shared by both walks sets the length:
// a climb that stops at band c takes c+1 compares, and a descent from the stored
// band h never goes below c, so it takes at most h-c+1 more. the band count is
// clamped to eight. from accept to the next accept a sample also passes the
// finish and idle states, plus any wait for the result register to drain. the
// sample side is not ready until the current sample is finished. configuration
// writes are always ready and do not clear the band state; the band count and
// hysteresis apply from the next sample, thresholds and rpms also mid-sample.
module fan_curve_band_governor
  import fcbg_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  fcbg_cfg_if.sink      cfg_i,
  fcbg_sample_if.sink   sample_i,
  fcbg_result_if.source result_o
);

  fcbg_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  // register file, writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_count      <= 4'd5;
      cfg_q.hysteresis_deg  <= 4'd3;
      cfg_q.threshold_table <= 56'd24875557042;
      cfg_q.rpm_table_low   <= 56'd35185768005634400;
      cfg_q.rpm_table_mid   <= 56'd147464500;
      cfg_q.rpm_table_top   <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_BAND_COUNT: cfg_q.band_count      <= cfg_i.data[BandWidth-1:0];
        CFG_HYSTERESIS: cfg_q.hysteresis_deg  <= cfg_i.data[HystWidth-1:0];
        CFG_THRESHOLDS: cfg_q.threshold_table <= cfg_i.data[TableWidth-1:0];
        CFG_RPM_LOW:    cfg_q.rpm_table_low   <= cfg_i.data[TableWidth-1:0];
        CFG_RPM_MID:    cfg_q.rpm_table_mid   <= cfg_i.data[TableWidth-1:0];
        CFG_RPM_TOP:    cfg_q.rpm_table_top   <= cfg_i.data[RpmWidth-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // band walk sequencer with the shared comparator and result register
  fcbg_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sample_i (sample_i),
    .result_o (result_o)
  );

endmodule

>>> tb/tb_fan_curve_band_governor.sv
`timescale 1ns / 1ps

module tb_fan_curve_band_governor;
  import fcbg_pkg::*;

  typedef struct packed {
    logic [TempWidth-1:0] mdeg;
    logic                 ok;
  } sample_t;

  typedef struct packed {
    logic [RpmWidth-1:0]  rpm;
    logic [BandWidth-1:0] band;
  } floor_req_t;

  localparam int NumPhases   = 12;
  localparam int PhaseItems  = 120;
  localparam int QuietCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  fcbg_cfg_if    cfg ();
  fcbg_sample_if smp ();
  fcbg_result_if res ();

  fan_curve_band_governor dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (smp),
    .result_o (res)
  );

  // register copies, loaded with the reset values
  logic [BandWidth-1:0]  band_cnt  = 4'd5;
  logic [HystWidth-1:0]  hyst_deg  = 4'd3;
  logic [TableWidth-1:0] thr_tbl   = 56'd24875557042;
  logic [TableWidth-1:0] rpm_lo    = 56'd35185768005634400;
  logic [TableWidth-1:0] rpm_mid   = 56'd147464500;
  logic [RpmWidth-1:0]   rpm_top   = 14'd0;

  // governor state as the block should hold it
  bit                  started_q = 1'b0;
  int                  cur_band  = 0;
  logic [RpmWidth-1:0] last_rpm  = '0;

  sample_t    samples_to_send[$];
  floor_req_t floor_due_q[$];

  int fail_count   = 0;
  int walk_mdeg    = 25000;
  int send_gap     = 0;
  int stall_left   = 0;
  bit sample_taken = 1'b0;
  bit src_idle_en  = 1'b0;
  bit snk_stall_en = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic int thr_mdeg(input int i);
    return int'(thr_tbl[7*i +: 7]) * int'(MdegPerDeg);
  endfunction

  function automatic logic [RpmWidth-1:0] band_rpm(input int b);
    if (b < 4) return rpm_lo[14*b +: 14];
    if (b < 8) return rpm_mid[14*(b-4) +: 14];
    return rpm_top;
  endfunction

  // one sample through the governor: band selection, hysteresis, rpm change filter
  task automatic governor_step(input int t, input logic ok_in);
    int                  bands;
    int                  nxt;
    int                  held;
    int                  hyst_m;
    bit                  ok;
    logic [RpmWidth-1:0] rpm;
    floor_req_t          req;
    bands = (band_cnt > NumBands) ? int'(NumBands) : int'(band_cnt);
    ok = (ok_in === 1'b1) && t >= int'(TempMinMdeg) && t <= int'(TempMaxMdeg);
    nxt = 0;
    if (!ok) begin
      nxt = bands;
    end else begin
      hyst_m = int'(hyst_deg) * int'(MdegPerDeg);
      while (nxt < bands && t >= thr_mdeg(nxt)) nxt++;
      if (started_q) begin
        held = (cur_band > bands) ? bands : cur_band;
        if (nxt < held) begin
          nxt = held;
          while (nxt > 0 && t < thr_mdeg(nxt - 1) - hyst_m) nxt--;
        end
      end
    end
    rpm = band_rpm(nxt);
    if (!started_q || rpm != last_rpm) begin
      last_rpm = rpm;
      req.rpm  = rpm;
      req.band = BandWidth'(nxt);
      floor_due_q.push_back(req);
    end
    started_q = 1'b1;
    cur_band  = nxt;
  endtask

  // results are checked before the sample of the same edge is predicted
  always @(posedge clk_i) begin : governor_watch
    floor_req_t want;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        if (floor_due_q.size() == 0) begin
          note_mismatch($sformatf("unexpected floor request rpm %0d band %0d",
                                  res.floor_rpm, res.band_index));
        end else begin
          want = floor_due_q.pop_front();
          if (res.floor_rpm !== want.rpm)
            note_mismatch($sformatf("floor_rpm %0d, want %0d", res.floor_rpm, want.rpm));
          if (res.band_index !== want.band)
            note_mismatch($sformatf("band_index %0d, want %0d", res.band_index, want.band));
        end
      end
      sample_taken = smp.valid && smp.ready;
      if (sample_taken) governor_step(int'(smp.temperature_mdeg), smp.temperature_valid);
    end else begin
      sample_taken = 1'b0;
    end
  end

  // sample requests, with idle bursts after an accepted sample
  always @(negedge clk_i) begin : sample_driver
    sample_t nxt;
    if (rst_ni && (sample_taken || !smp.valid)) begin
      if (sample_taken && src_idle_en && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 13);
      if (send_gap > 0) begin
        smp.valid <= 1'b0;
        send_gap--;
      end else if (samples_to_send.size() != 0) begin
        nxt = samples_to_send.pop_front();
        smp.valid             <= 1'b1;
        smp.temperature_mdeg  <= nxt.mdeg;
        smp.temperature_valid <= nxt.ok;
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // result backpressure in bursts
  always @(negedge clk_i) begin : result_stall
    if (rst_ni) begin
      if (stall_left == 0 && snk_stall_en && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic queue_sample(input int mdeg, input logic ok);
    sample_t s;
    s.mdeg = mdeg[TempWidth-1:0];
    s.ok   = ok;
    samples_to_send.push_back(s);
  endtask

  // mostly a slow drift and threshold edges so the hysteresis walk gets exercised
  task automatic queue_random_sample();
    int mode;
    int v;
    logic ok;
    mode = $urandom_range(0, 99);
    ok = 1'b1;
    if (mode < 55) begin
      walk_mdeg += int'($urandom_range(0, 8000)) - 4000;
      if (walk_mdeg < int'(TempMinMdeg)) walk_mdeg = int'(TempMinMdeg);
      if (walk_mdeg > int'(TempMaxMdeg)) walk_mdeg = int'(TempMaxMdeg);
      v = walk_mdeg;
    end else if (mode < 80) begin
      // on a threshold, or on its lower hysteresis edge
      v = thr_mdeg($urandom_range(0, 7)) + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1) == 1) v -= int'(hyst_deg) * int'(MdegPerDeg);
      walk_mdeg = v;
    end else if (mode < 88) begin
      v = int'($urandom_range(0, 190000)) + int'(TempMinMdeg);
    end else if (mode < 94) begin
      v = int'($urandom_range(0, 190000)) + int'(TempMinMdeg);
      ok = 1'b0;
    end else begin
      // full raw range, out-of-range samples included
      v = int'($urandom);
      ok = 1'($urandom_range(0, 1));
    end
    queue_sample(v, ok);
  endtask

  task automatic write_reg(input fcbg_cfg_idx_e idx, input logic [CfgDatWidth-1:0] value);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = value;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    case (idx)
      CFG_BAND_COUNT: band_cnt = value[BandWidth-1:0];
      CFG_HYSTERESIS: hyst_deg = value[HystWidth-1:0];
      CFG_THRESHOLDS: thr_tbl  = value[TableWidth-1:0];
      CFG_RPM_LOW:    rpm_lo   = value[TableWidth-1:0];
      CFG_RPM_MID:    rpm_mid  = value[TableWidth-1:0];
      CFG_RPM_TOP:    rpm_top  = value[RpmWidth-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  // block must be idle before a register write: nothing pending, nothing owed
  task automatic wait_for_quiet();
    int spent;
    spent = 0;
    while ((samples_to_send.size() != 0 || smp.valid || floor_due_q.size() != 0) &&
           spent < 20000) begin
      @(posedge clk_i);
      spent++;
    end
    if (floor_due_q.size() != 0) begin
      note_mismatch($sformatf("%0d floor requests never arrived", floor_due_q.size()));
      floor_due_q.delete();
    end
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  function automatic logic [TableWidth-1:0] sorted_thresholds();
    logic [TableWidth-1:0] w;
    int deg;
    deg = $urandom_range(0, 40);
    for (int i = 0; i < 8; i++) begin
      w[7*i +: 7] = 7'(deg);
      deg += $urandom_range(0, 16);
      if (deg > 127) deg = 127;
    end
    return w;
  endfunction

  function automatic logic [TableWidth-1:0] two_level_rpm();
    logic [TableWidth-1:0] w;
    logic [RpmWidth-1:0]   a;
    logic [RpmWidth-1:0]   b;
    a = RpmWidth'($urandom);
    b = RpmWidth'($urandom);
    for (int i = 0; i < 4; i++) w[14*i +: 14] = ($urandom_range(0, 1) == 1) ? a : b;
    return w;
  endfunction

  initial begin : run_sequence
    logic [BandWidth-1:0]  bc;
    logic [HystWidth-1:0]  hy;
    logic [TableWidth-1:0] thr;
    logic [TableWidth-1:0] lo;
    logic [TableWidth-1:0] mid;
    logic [RpmWidth-1:0]   top;
    int                    hy_m;
    rst_ni                = 1'b0;
    smp.valid             = 1'b0;
    smp.temperature_mdeg  = '0;
    smp.temperature_valid = 1'b0;
    res.ready             = 1'b0;
    cfg.valid             = 1'b0;
    cfg.index             = CFG_BAND_COUNT;
    cfg.data              = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed part on the reset settings
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    hy_m = int'(hyst_deg) * int'(MdegPerDeg);
    queue_sample(0, 1'b1);                  // first sample always reports
    for (int i = 0; i < 5; i++) begin       // climb each threshold edge
      queue_sample(thr_mdeg(i) - 1, 1'b1);
      queue_sample(thr_mdeg(i), 1'b1);
    end
    queue_sample(int'(TempMaxMdeg), 1'b1);
    queue_sample(int'(TempMaxMdeg) + 1, 1'b1);   // out of range goes to the top band
    queue_sample(int'(TempMinMdeg), 1'b1);
    queue_sample(int'(TempMinMdeg) - 1, 1'b1);
    queue_sample(0, 1'b0);                       // sensor failure
    queue_sample(-262144, 1'b1);
    queue_sample(262143, 1'b1);
    queue_sample(-262144, 1'b0);
    queue_sample(thr_mdeg(4) - hy_m, 1'b1);      // on the hysteresis edge: holds
    queue_sample(thr_mdeg(4) - hy_m - 1, 1'b1);  // just below: steps down
    queue_sample(int'(TempMinMdeg), 1'b1);
    wait_for_quiet();

    for (int p = 0; p < NumPhases; p++) begin
      bc  = BandWidth'($urandom_range(1, 8));
      hy  = HystWidth'($urandom_range(0, 10));
      thr = sorted_thresholds();
      lo  = TableWidth'({$urandom, $urandom});
      mid = TableWidth'({$urandom, $urandom});
      top = RpmWidth'($urandom);
      case (p)
        0: begin bc = 4'd8; hy = 4'd0; end
        1: begin bc = 4'd1; hy = 4'd10; end
        2: begin bc = 4'd0; hy = 4'd15; end
        3: begin
          // too many bands, unordered thresholds
          bc  = 4'd15;
          hy  = HystWidth'($urandom);
          thr = TableWidth'({$urandom, $urandom});
        end
        4: begin thr = '0; lo = '1; mid = '1; top = '1; end
        5: begin bc = 4'd8; thr = '1; lo = '0; mid = '0; top = '0; end
        6: begin
          bc  = BandWidth'($urandom_range(9, 14));
          lo  = two_level_rpm();
          mid = two_level_rpm();
        end
        default: ;
      endcase
      write_reg(CFG_BAND_COUNT, CfgDatWidth'(bc));
      write_reg(CFG_HYSTERESIS, CfgDatWidth'(hy));
      write_reg(CFG_THRESHOLDS, thr);
      write_reg(CFG_RPM_LOW, lo);
      write_reg(CFG_RPM_MID, mid);
      write_reg(CFG_RPM_TOP, CfgDatWidth'(top));

      // last phase runs at full rate on both sides
      src_idle_en  = (p != NumPhases - 1) && $urandom_range(0, 3) != 0;
      snk_stall_en = (p != NumPhases - 1) && $urandom_range(0, 3) != 0;
      for (int n = 0; n < PhaseItems; n++) queue_random_sample();
      // park in the top band so a smaller band count next phase must clamp it
      if (p != NumPhases - 1) queue_sample(0, 1'b0);
      wait_for_quiet();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
